[src/fde_pkg.sv]
// Shared types and constants for the framebuffer draw engine.
`timescale 1ns / 1ps
`default_nettype none
package fde_pkg;
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_FRAC_BITS  = 16;
    localparam int CFG_W          = 7;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] REG_RASTER_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RASTER_HEIGHT = 1'd1;

    typedef enum logic [2:0] {
        ACT_PIXEL = 3'd0,
        ACT_LINE  = 3'd1,
        ACT_RECT  = 3'd2,
        ACT_GRID  = 3'd3,
        ACT_CLEAR = 3'd4,
        ACT_READ  = 3'd5
    } t_action;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic [14:0]        rect_width;
        logic [14:0]        rect_height;
        logic [11:0]        col_pitch;
        logic [11:0]        row_pitch;
        logic [31:0]        color;
    } t_cmd;

    typedef struct packed {
        logic        status;
        logic [31:0] read_color;
    } t_result;

    // Pixel request from the command sequencer to the frame store.
    typedef struct packed {
        logic        wr;
        logic        rd;
        logic [23:0] addr;
        logic [31:0] data;
    } t_mem_req;
endpackage
`default_nettype wire

[src/framebuffer_draw_engine.sv]
// Top level of the framebuffer draw engine: command sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
// One command is taken at a time and yields one result transaction. The
// sequencer visits one position per cycle through a single-port frame memory,
// and a command passes through accept and result plus its visits: a pixel
// write or an in-raster read makes one visit, an out-of-raster read, an
// unknown action or a refused line none, and on a nonempty raster a clear
// visits each position once and a grid twice, since a grid sweeps the raster
// once per direction. A rectangle visits each position of its clipped area,
// with at least one visit per clipped row even when it lies off the right
// edge. A line whose start is inside runs the two step divisions and then
// makes one visit per DDA position (max(|dx|,|dy|)). A finished command waits
// while an earlier result is still held, keeping the input stalled. Frame
// contents are undefined until written; no clearing pass runs after reset.
module framebuffer_draw_engine
    import fde_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire t_cmd                 i_cmd,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output t_result                   o_result,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);
    localparam int DW = FRAC_BITS + 18;   // quotient width
    localparam int PW = DW + 18;          // DDA position width

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DIV, S_LINE, S_READ, S_DONE
    } t_state;

    t_state        r_state;
    t_cmd          r_cmd;
    logic          r_status;
    logic [6:0]    r_rw, r_rh;
    logic [12:0]   w_w, w_h;
    logic signed [17:0] r_x, r_y, r_xa, r_xb, r_yb;
    logic [12:0]   r_hcnt, r_vcnt;
    logic          r_pass;   // grid: 0 rows, 1 columns
    logic [16:0]   r_len, r_i;
    logic signed [PW-1:0] r_px, r_py;
    logic signed [DW-1:0] r_sx, r_sy;
    logic          r_div_y;
    logic          r_div_start;
    logic signed [16:0] w_div_delta;
    logic          w_div_done;
    logic signed [DW-1:0] w_quot;
    t_mem_req      w_req;
    logic [31:0]   w_rdata;
    logic          w_accept;
    logic signed [17:0] w_dx, w_dy, w_adx, w_ady, w_idx, w_idy;
    logic signed [17:0] w_rx, w_ry;

    function automatic logic in_rast(input logic signed [17:0] x, input logic signed [17:0] y,
                                     input logic [12:0] w, input logic [12:0] h);
        return x >= 0 && x < $signed({5'd0, w}) && y >= 0 && y < $signed({5'd0, h});
    endfunction

    function automatic logic signed [17:0] fx_round(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] m;
        logic signed [PW-1:0] h;
        h = PW'(1) <<< (FRAC_BITS - 1);
        if (p >= 0) return 18'((p + h) >>> FRAC_BITS);
        m = -p;
        return -18'((m + h) >>> FRAC_BITS);
    endfunction

    assign w_w = ({6'd0, r_rw} > 13'(MAX_WIDTH))  ? 13'(MAX_WIDTH)  : {6'd0, r_rw};
    assign w_h = ({6'd0, r_rh} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : {6'd0, r_rh};

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;

    assign w_dx  = 18'(r_cmd.x1) - 18'(r_cmd.x0);
    assign w_dy  = 18'(r_cmd.y1) - 18'(r_cmd.y0);
    // Line length comes from the incoming command so the divider has it at start.
    assign w_idx = 18'(i_cmd.x1) - 18'(i_cmd.x0);
    assign w_idy = 18'(i_cmd.y1) - 18'(i_cmd.y0);
    assign w_adx = w_idx < 0 ? -w_idx : w_idx;
    assign w_ady = w_idy < 0 ? -w_idy : w_idy;
    assign w_div_delta = r_div_y ? 17'(w_dy) : 17'(w_dx);
    assign w_rx  = fx_round(r_px);
    assign w_ry  = fx_round(r_py);

    fde_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_start),
        .i_delta(w_div_delta), .i_len(r_len), .o_done(w_div_done), .o_quot(w_quot)
    );

    always_comb begin
        w_req      = '0;
        w_req.data = r_cmd.color;
        case (r_state)
            S_SCAN: begin
                w_req.addr = 24'(r_x) + 24'(r_y) * 24'(w_w);
                w_req.wr   = r_x >= r_xa && r_x < r_xb && r_y < r_yb
                             && in_rast(r_x, r_y, w_w, w_h);
                if (r_cmd.action == ACT_GRID)
                    w_req.wr = in_rast(r_x, r_y, w_w, w_h) &&
                        (r_pass ? (r_hcnt == r_cmd.col_pitch && r_x != 0)
                                : (r_vcnt == r_cmd.row_pitch && r_y != 0));
            end
            S_LINE: begin
                w_req.addr = 24'(w_rx) + 24'(w_ry) * 24'(w_w);
                w_req.wr   = in_rast(w_rx, w_ry, w_w, w_h);
            end
            S_READ: begin
                w_req.addr = 24'(r_cmd.x0) + 24'(r_cmd.y0) * 24'(w_w);
                w_req.rd   = 1'b1;
            end
            default: ;
        endcase
    end

    fde_frame_store #(.DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_store (
        .i_clk(i_clk), .i_req(w_req), .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_div_start <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_rw    <= 7'd64;
            r_rh    <= 7'd64;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_RASTER_WIDTH)  r_rw <= i_cfg_data;
                if (i_cfg_index == REG_RASTER_HEIGHT) r_rh <= i_cfg_data;
            end
            if (o_valid && !i_stall) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd  <= i_cmd;
                        r_status <= 1'b0;
                        r_x    <= '0;
                        r_y    <= '0;
                        r_pass <= 1'b0;
                        r_hcnt <= '0;
                        r_vcnt <= '0;
                        r_xa   <= '0;
                        r_xb   <= {5'd0, w_w};
                        r_yb   <= {5'd0, w_h};
                        r_state <= S_DONE;
                        case (i_cmd.action)
                            ACT_PIXEL: begin
                                r_xa <= 18'(i_cmd.x0);
                                r_xb <= 18'(i_cmd.x0) + 18'sd1;
                                r_x  <= 18'(i_cmd.x0);
                                r_y  <= 18'(i_cmd.y0);
                                r_yb <= 18'(i_cmd.y0) + 18'sd1;
                                r_state <= S_SCAN;
                            end
                            ACT_RECT: begin
                                r_xa <= i_cmd.x0 < 0 ? 18'sd0 : 18'(i_cmd.x0);
                                r_x  <= i_cmd.x0 < 0 ? 18'sd0 : 18'(i_cmd.x0);
                                r_y  <= i_cmd.y0 < 0 ? 18'sd0 : 18'(i_cmd.y0);
                                r_xb <= 18'(i_cmd.x0) + $signed({3'd0, i_cmd.rect_width});
                                r_yb <= 18'(i_cmd.y0) + $signed({3'd0, i_cmd.rect_height});
                                r_state <= S_SCAN;
                            end
                            ACT_GRID, ACT_CLEAR: r_state <= S_SCAN;
                            ACT_LINE: begin
                                if (!in_rast(18'(i_cmd.x0), 18'(i_cmd.y0), w_w, w_h))
                                    r_status <= 1'b1;
                                else begin
                                    r_state <= S_DIV;
                                    r_div_start <= 1'b1;
                                    r_div_y <= 1'b0;
                                end
                            end
                            ACT_READ: begin
                                if (in_rast(18'(i_cmd.x0), 18'(i_cmd.y0), w_w, w_h))
                                    r_state <= S_READ;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    // Clipped sweep; a row ends at the right edge of the rectangle or of the raster.
                    if (r_x + 18'sd1 >= r_xb || r_x + 18'sd1 >= $signed({5'd0, w_w})) begin
                        r_x <= r_xa;
                        r_hcnt <= '0;
                        r_y <= r_y + 18'sd1;
                        r_vcnt <= (r_vcnt == r_cmd.row_pitch) ? 13'd1 : r_vcnt + 13'd1;
                        if (r_y + 18'sd1 >= r_yb || r_y + 18'sd1 >= $signed({5'd0, w_h})) begin
                            if (r_cmd.action == ACT_GRID && !r_pass) begin
                                r_pass <= 1'b1;
                                r_y <= '0;
                                r_vcnt <= '0;
                            end else
                                r_state <= S_DONE;
                        end
                    end else begin
                        r_x <= r_x + 18'sd1;
                        r_hcnt <= (r_hcnt == r_cmd.col_pitch) ? 13'd1 : r_hcnt + 13'd1;
                    end
                    if (r_xb <= r_xa || r_yb <= r_y) r_state <= S_DONE;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        if (!r_div_y) begin
                            r_sx <= w_quot;
                            r_div_y <= 1'b1;
                            r_div_start <= 1'b1;
                        end else begin
                            r_sy <= w_quot;
                            r_i  <= '0;
                            r_px <= PW'(r_cmd.x0) <<< FRAC_BITS;
                            r_py <= PW'(r_cmd.y0) <<< FRAC_BITS;
                            r_state <= (r_len == 0) ? S_DONE : S_LINE;
                        end
                    end
                end
                S_LINE: begin
                    r_px <= r_px + PW'(r_sx);
                    r_py <= r_py + PW'(r_sy);
                    r_i  <= r_i + 17'd1;
                    if (r_i + 17'd1 == r_len) r_state <= S_DONE;
                end
                S_READ: r_state <= S_DONE;
                S_DONE: begin
                    if (!o_valid || !i_stall) begin
                        o_result.status <= r_status;
                        o_result.read_color <= (r_cmd.action == ACT_READ &&
                            in_rast(18'(r_cmd.x0), 18'(r_cmd.y0), w_w, w_h))
                            ? w_rdata : 32'd0;
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_IDLE && w_accept)
                r_len <= (w_adx >= w_ady) ? 17'(w_adx) : 17'(w_ady);
        end
    end

    // A result can only appear once the sequencer has finished its command.
    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside done state");
    // No new command is taken while one is in progress.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("accept while busy");
    // The frame memory never reads and writes in the same cycle.
    a_mem_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_req.wr && w_req.rd))
        else $error("frame memory port conflict");
endmodule
`default_nettype wire

[src/fde_divider.sv]
// Restoring signed divider computing the DDA step (delta << FRAC_BITS) / len.
`timescale 1ns / 1ps
`default_nettype none
module fde_divider
    import fde_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic signed [16:0]            i_delta,
    input  wire logic [16:0]                   i_len,
    output logic                               o_done,
    output logic signed [FRAC_BITS+17:0]       o_quot
);
    localparam int NW = FRAC_BITS + 17;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_num, n_num;
    logic [17:0]   r_rem, n_rem;
    logic [16:0]   r_den;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [17:0]   w_trial;
    logic [16:0]   w_mag;

    assign w_mag   = i_delta[16] ? 17'(-i_delta) : 17'(i_delta);
    assign w_trial = {r_rem[16:0], r_num[NW-1]} - {1'b0, r_den};

    always_comb begin
        n_num = {r_num[NW-2:0], 1'b0};
        n_rem = {r_rem[16:0], r_num[NW-1]};
        if (!w_trial[17]) begin
            n_rem    = w_trial;
            n_num[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_num  <= {w_mag, {FRAC_BITS{1'b0}}};
            r_rem  <= '0;
            r_den  <= i_len;
            r_neg  <= i_delta[16];
            r_cnt  <= CW'(NW);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end

    assign o_quot = r_neg ? -$signed({1'b0, r_num}) : $signed({1'b0, r_num});
endmodule
`default_nettype wire

[src/fde_frame_store.sv]
// Synchronous single-port frame memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fde_frame_store
    import fde_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT
) (
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output logic [31:0]   o_rdata
);
    localparam int AW = $clog2(DEPTH);
    logic [31:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.wr) r_mem[i_req.addr[AW-1:0]] <= i_req.data;
        if (i_req.rd) o_rdata <= r_mem[i_req.addr[AW-1:0]];
    end
endmodule
`default_nettype wire
